// ===== rtl/core/hrkd_pkg.sv =====
package hrkd_pkg;

  // Report and field geometry.
  localparam int BYTE_FIELDS = 8;
  localparam int KEY_W       = 8;
  localparam int IDX_W       = 3;
  localparam int LEN_W       = 4;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECODER_KIND    = 3'd0,
    REG_PREFERRED_INDEX = 3'd1,
    REG_ACTION_A_CODE   = 3'd2,
    REG_ACTION_B_CODE   = 3'd3,
    REG_FORWARD_CODE    = 3'd4,
    REG_BACK_CODE       = 3'd5
  } cfg_reg_t;

  // Decoder kinds. The unused code falls back to generic extraction.
  localparam logic [1:0] KIND_GENERIC = 2'd0;
  localparam logic [1:0] KIND_GAMEPAD = 2'd1;
  localparam logic [1:0] KIND_ROLLING = 2'd2;

  // Keycode constants.
  localparam logic [KEY_W-1:0] KEY_NONE    = 8'h00;
  localparam logic [KEY_W-1:0] KEY_FILL    = 8'hFF;
  localparam logic [KEY_W-1:0] ROLL_MIN    = 8'h04;
  localparam logic [KEY_W-1:0] ARROW_RIGHT = 8'h4F;
  localparam logic [KEY_W-1:0] ARROW_LEFT  = 8'h50;

  // Gamepad report constants.
  localparam logic [15:0]      FREEZE_COUNTER = 16'h07D0;
  localparam logic [KEY_W-1:0] CENTRE_X       = 8'h98;
  localparam logic [KEY_W-1:0] CENTRE_FIRE    = 8'd6;
  localparam logic [KEY_W-1:0] CENTRE_MAX     = 8'hFF;
  localparam logic [3:0]       STABLE_NIBBLE  = 4'h1;
  localparam logic [LEN_W-1:0] GP_MIN_LEN     = 4'd5;
  localparam logic [KEY_W-1:0] PAD_DIR_A      = 8'h07;
  localparam logic [KEY_W-1:0] PAD_CENTRE     = 8'h08;
  localparam logic [KEY_W-1:0] PAD_DIR_B      = 8'h09;

  localparam logic [KEY_W-1:0] NAV_CODES [12] = '{
    8'hE9, 8'hEA, 8'h4B, 8'h4E, 8'h52, 8'h51,
    8'h50, 8'h4F, 8'h2C, 8'h28, 8'h80, 8'h81
  };

  typedef logic [BYTE_FIELDS-1:0][KEY_W-1:0] report_t;

  typedef struct packed {
    logic [1:0]       decoder_kind;
    logic [KEY_W-1:0] preferred_index;
    logic [KEY_W-1:0] action_a_code;
    logic [KEY_W-1:0] action_b_code;
    logic [KEY_W-1:0] forward_code;
    logic [KEY_W-1:0] back_code;
  } cfg_t;

  typedef struct packed {
    logic             pressed;
    logic [IDX_W-1:0] source_index;
    logic [KEY_W-1:0] keycode;
  } frame_t;

  typedef struct packed {
    logic [15:0]      last_counter;
    logic [KEY_W-1:0] latched_direction;
    logic [KEY_W-1:0] center_frames;
  } gp_state_t;

  function automatic logic is_key(input logic [KEY_W-1:0] c);
    return (c != KEY_NONE) && (c != KEY_FILL);
  endfunction

  function automatic logic is_nav(input logic [KEY_W-1:0] c);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < 12; k++) begin
      if (NAV_CODES[k] == c) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic in_forward(input logic [KEY_W-1:0] c);
    return (c == 8'h1C) || (c == 8'hC4) || (c == 8'h6C) || (c == 8'hBC);
  endfunction

  function automatic logic in_back(input logic [KEY_W-1:0] c);
    return (c == 8'hB4) || (c == 8'h0E) || (c == 8'h66) || (c == 8'h16);
  endfunction

  // Lowest set bit: {found, index}.
  function automatic logic [IDX_W:0] first_one(input logic [BYTE_FIELDS-1:0] v);
    logic [IDX_W:0] res;
    res = '0;
    for (int i = BYTE_FIELDS - 1; i >= 0; i--) begin
      if (v[i]) res = {1'b1, IDX_W'(i)};
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/hid_report_key_decoder_unit.sv =====
// Channel   | Signals                                   | Contents (lowest bits first)
// ----------+-------------------------------------------+----------------------------------
// report in | s_axis_tvalid/tready/tdata[71:0]          | byte0..byte7, report_length, pad
// frame out | m_axis_tvalid/tready/tdata[15:0]          | keycode, source_index, pressed, pad
// config    | cfg_we, cfg_index[2:0], cfg_data[7:0]     | register write, no read-back
//
// Each accepted report is held in the input register, decoded by the single combinational
// decode stage and captured in the result register; one report per cycle is sustained
// when the output side does not stall. Reset is synchronous and active high: it empties
// both registers, restores the configuration defaults and clears the gamepad state.
// A stall on the output holds the result; the input register keeps taking one more
// report, and further reports wait until the result transfer completes.
module hid_report_key_decoder_unit #(
  parameter int REPORT_BYTES = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // byte0 [7:0] .. byte7 [63:56], report_length [67:64], zero pad [71:68]
  input  logic [hrkd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // keycode [7:0], source_index [10:8], pressed [11], zero pad [15:12]
  output logic [hrkd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                                cfg_we,
  input  logic [hrkd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hrkd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Bytes beyond this window are ignored even when the length claims them.
  localparam int WINDOW = (REPORT_BYTES < hrkd_pkg::BYTE_FIELDS) ? REPORT_BYTES
                                                                 : hrkd_pkg::BYTE_FIELDS;
  localparam logic [hrkd_pkg::LEN_W-1:0] WINDOW_LEN = hrkd_pkg::LEN_W'(WINDOW);

  logic                          in_valid;
  hrkd_pkg::report_t             in_report;
  logic [hrkd_pkg::LEN_W-1:0]    in_len;
  logic                          out_valid;
  hrkd_pkg::frame_t              out_frame;
  hrkd_pkg::cfg_t                cfg;
  hrkd_pkg::gp_state_t           gp_state;

  logic                          advance;
  logic                          take_in;
  logic [hrkd_pkg::LEN_W-1:0]    len_clamped;
  hrkd_pkg::frame_t              generic_frame;
  hrkd_pkg::frame_t              rolling_frame;
  hrkd_pkg::frame_t              gamepad_frame;
  hrkd_pkg::gp_state_t           gp_state_next;
  hrkd_pkg::frame_t              frame_next;

  // The decode stage moves on whenever the result register is empty or being emptied.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !rst && (!in_valid || advance);
  assign take_in       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take_in) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      in_report <= s_axis_tdata[hrkd_pkg::BYTE_FIELDS*hrkd_pkg::KEY_W-1:0];
      in_len    <= s_axis_tdata[hrkd_pkg::BYTE_FIELDS*hrkd_pkg::KEY_W +: hrkd_pkg::LEN_W];
    end
  end

  assign len_clamped = (in_len > WINDOW_LEN) ? WINDOW_LEN : in_len;

  hrkd_scan u_scan (
    .report        (in_report),
    .len           (len_clamped),
    .cfg           (cfg),
    .generic_frame (generic_frame),
    .rolling_frame (rolling_frame)
  );

  hrkd_gamepad u_gamepad (
    .report     (in_report),
    .len        (len_clamped),
    .cfg        (cfg),
    .state      (gp_state),
    .frame      (gamepad_frame),
    .state_next (gp_state_next)
  );

  always_comb begin
    case (cfg.decoder_kind)
      hrkd_pkg::KIND_GAMEPAD: frame_next = gamepad_frame;
      hrkd_pkg::KIND_ROLLING: frame_next = rolling_frame;
      default:                frame_next = generic_frame;
    endcase
  end

  // Gamepad tracking state only moves when a report is decoded in gamepad mode.
  always_ff @(posedge clk) begin
    if (rst) begin
      gp_state <= '0;
    end else if (advance && cfg.decoder_kind == hrkd_pkg::KIND_GAMEPAD) begin
      gp_state <= gp_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_frame <= frame_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(hrkd_pkg::OUT_TDATA_W - $bits(hrkd_pkg::frame_t)){1'b0}}, out_frame};

  // Configuration registers. Writes to indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decoder_kind    <= hrkd_pkg::KIND_GENERIC;
      cfg.preferred_index <= 8'd255;
      cfg.action_a_code   <= 8'd240;
      cfg.action_b_code   <= 8'd241;
      cfg.forward_code    <= 8'd242;
      cfg.back_code       <= 8'd243;
    end else if (cfg_we) begin
      unique case (hrkd_pkg::cfg_reg_t'(cfg_index))
        hrkd_pkg::REG_DECODER_KIND:    cfg.decoder_kind    <= cfg_data[1:0];
        hrkd_pkg::REG_PREFERRED_INDEX: cfg.preferred_index <= cfg_data;
        hrkd_pkg::REG_ACTION_A_CODE:   cfg.action_a_code   <= cfg_data;
        hrkd_pkg::REG_ACTION_B_CODE:   cfg.action_b_code   <= cfg_data;
        hrkd_pkg::REG_FORWARD_CODE:    cfg.forward_code    <= cfg_data;
        hrkd_pkg::REG_BACK_CODE:       cfg.back_code       <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/hrkd_scan.sv =====
// Stateless byte scans for generic extraction and rolling code folding.
module hrkd_scan (
  input  hrkd_pkg::report_t               report,
  input  logic [hrkd_pkg::LEN_W-1:0]      len,
  input  hrkd_pkg::cfg_t                  cfg,
  output hrkd_pkg::frame_t                generic_frame,
  output hrkd_pkg::frame_t                rolling_frame
);

  logic [hrkd_pkg::BYTE_FIELDS-1:0] in_win;
  logic [hrkd_pkg::BYTE_FIELDS-1:0] nav_hit;
  logic [hrkd_pkg::BYTE_FIELDS-1:0] slot_hit;
  logic [hrkd_pkg::BYTE_FIELDS-1:0] any_hit;
  logic [hrkd_pkg::BYTE_FIELDS-1:0] roll_hit;
  logic [hrkd_pkg::IDX_W:0]         nav_pick;
  logic [hrkd_pkg::IDX_W:0]         slot_pick;
  logic [hrkd_pkg::IDX_W:0]         any_pick;
  logic [hrkd_pkg::IDX_W:0]         roll_pick;
  logic [hrkd_pkg::IDX_W-1:0]       hint_idx;
  logic                             hint_hit;
  logic [hrkd_pkg::KEY_W-1:0]       roll_byte;

  always_comb begin
    for (int i = 0; i < hrkd_pkg::BYTE_FIELDS; i++) begin
      in_win[i]   = hrkd_pkg::LEN_W'(i) < len;
      nav_hit[i]  = in_win[i] && hrkd_pkg::is_nav(report[i]);
      slot_hit[i] = in_win[i] && (i >= 2) && hrkd_pkg::is_key(report[i]);
      any_hit[i]  = in_win[i] && hrkd_pkg::is_key(report[i]);
      roll_hit[i] = any_hit[i] && (hrkd_pkg::in_forward(report[i]) ||
                    hrkd_pkg::in_back(report[i]) || (report[i] >= hrkd_pkg::ROLL_MIN));
    end
  end

  assign nav_pick  = hrkd_pkg::first_one(nav_hit);
  assign slot_pick = hrkd_pkg::first_one(slot_hit);
  assign any_pick  = hrkd_pkg::first_one(any_hit);
  assign roll_pick = hrkd_pkg::first_one(roll_hit);

  // A hint below the clamped length always lands inside the eight bytes.
  assign hint_idx = cfg.preferred_index[hrkd_pkg::IDX_W-1:0];
  assign hint_hit = (cfg.preferred_index < {4'd0, len}) && hrkd_pkg::is_key(report[hint_idx]);

  always_comb begin
    generic_frame = '0;
    if (hint_hit) begin
      generic_frame = '{pressed: 1'b1, source_index: hint_idx, keycode: report[hint_idx]};
    end else if (nav_pick[hrkd_pkg::IDX_W]) begin
      generic_frame = '{pressed: 1'b1, source_index: nav_pick[hrkd_pkg::IDX_W-1:0],
                        keycode: report[nav_pick[hrkd_pkg::IDX_W-1:0]]};
    end else if (slot_pick[hrkd_pkg::IDX_W]) begin
      generic_frame = '{pressed: 1'b1, source_index: slot_pick[hrkd_pkg::IDX_W-1:0],
                        keycode: report[slot_pick[hrkd_pkg::IDX_W-1:0]]};
    end else if (any_pick[hrkd_pkg::IDX_W]) begin
      generic_frame = '{pressed: 1'b1, source_index: any_pick[hrkd_pkg::IDX_W-1:0],
                        keycode: report[any_pick[hrkd_pkg::IDX_W-1:0]]};
    end
  end

  assign roll_byte = report[roll_pick[hrkd_pkg::IDX_W-1:0]];

  always_comb begin
    rolling_frame = '0;
    if (roll_pick[hrkd_pkg::IDX_W]) begin
      rolling_frame.pressed      = 1'b1;
      rolling_frame.source_index = roll_pick[hrkd_pkg::IDX_W-1:0];
      if (hrkd_pkg::in_forward(roll_byte)) begin
        rolling_frame.keycode = cfg.forward_code;
      end else if (hrkd_pkg::in_back(roll_byte)) begin
        rolling_frame.keycode = cfg.back_code;
      end else begin
        rolling_frame.keycode = roll_byte;
      end
    end
  end

endmodule

// ===== rtl/core/hrkd_gamepad.sv =====
// Gamepad counter decode and the next value of the tracking state.
module hrkd_gamepad (
  input  hrkd_pkg::report_t          report,
  input  logic [hrkd_pkg::LEN_W-1:0] len,
  input  hrkd_pkg::cfg_t             cfg,
  input  hrkd_pkg::gp_state_t        state,
  output hrkd_pkg::frame_t           frame,
  output hrkd_pkg::gp_state_t        state_next
);

  localparam logic [hrkd_pkg::IDX_W-1:0] SRC_STICK  = 3'd3;
  localparam logic [hrkd_pkg::IDX_W-1:0] SRC_BUTTON = 3'd4;

  logic                       stable;
  logic                       active;
  logic                       frozen;
  logic [15:0]                counter;
  logic [hrkd_pkg::KEY_W-1:0] lat;
  logic [hrkd_pkg::KEY_W-1:0] b4;
  logic [hrkd_pkg::KEY_W-1:0] x;
  logic [hrkd_pkg::KEY_W-1:0] cf;

  assign stable  = (len >= hrkd_pkg::GP_MIN_LEN) &&
                   (report[0][7:4] == hrkd_pkg::STABLE_NIBBLE);
  assign active  = report[0][0];
  assign counter = {report[2], report[1]};
  assign frozen  = counter == state.last_counter;
  assign b4      = report[4];
  assign x       = report[3];

  always_comb begin
    frame      = '0;
    state_next = state;
    lat        = (!frozen || !active) ? '0 : state.latched_direction;
    cf         = '0;
    if (stable) begin
      if (b4 == hrkd_pkg::PAD_DIR_A || b4 == hrkd_pkg::PAD_DIR_B) begin
        if (counter == hrkd_pkg::FREEZE_COUNTER || (frozen && lat != '0)) begin
          // Inside the freeze window only the latched direction passes.
          if (lat == '0) lat = b4;
          if (b4 == lat) begin
            frame = '{pressed: active, source_index: SRC_BUTTON, keycode: b4};
          end
        end else begin
          frame = '{pressed: active, source_index: SRC_BUTTON,
                    keycode: (b4 == hrkd_pkg::PAD_DIR_A) ? cfg.action_a_code
                                                         : cfg.action_b_code};
        end
      end else if (b4 == hrkd_pkg::PAD_CENTRE) begin
        if (frozen && lat != '0) begin
          cf = '0;
        end else if ({1'b0, x} + 9'd2 < {1'b0, hrkd_pkg::CENTRE_X}) begin
          frame = '{pressed: active, source_index: SRC_STICK, keycode: hrkd_pkg::ARROW_RIGHT};
        end else if (x > hrkd_pkg::CENTRE_X) begin
          frame = '{pressed: active, source_index: SRC_STICK, keycode: hrkd_pkg::ARROW_LEFT};
        end else if (active && !frozen && lat == '0) begin
          // Centred frames count up and saturate; a long hold reads as LEFT.
          cf = (state.center_frames != hrkd_pkg::CENTRE_MAX) ? state.center_frames + 8'd1
                                                             : state.center_frames;
          if (cf >= hrkd_pkg::CENTRE_FIRE) begin
            frame = '{pressed: active, source_index: SRC_STICK,
                      keycode: hrkd_pkg::ARROW_LEFT};
          end
        end
      end
      state_next.last_counter      = counter;
      state_next.latched_direction = lat;
      state_next.center_frames     = cf;
    end
  end

endmodule

// ===== rtl/core/hrkd_checker.sv =====
module hrkd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [hrkd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // Reset empties the result side.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // A stalled result keeps its valid and its data.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // A rising result valid must trace back to a report accepted on the input.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a matching report");

  // Pad bits above the pressed flag stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[hrkd_pkg::OUT_TDATA_W-1:12] == '0)
    else $error("result pad bits set");

endmodule

bind hid_report_key_decoder_unit hrkd_checker u_hrkd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
